// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

  // Field widths of the request and result channels
  localparam int OP_W      = 2;
  localparam int CODE_W    = 8;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int OFF_W     = 11;
  localparam int WORD_W    = 16;
  localparam int COLOR_W   = 4;
  localparam int CFG_IDX_W = 1;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_SETCUR = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

  // Character codes with special handling
  localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;

  localparam int TAB_STOP = 8;

  // Blank cell after reset: space, attribute zero
  localparam logic [WORD_W-1:0] RESET_WORD = 16'h0020;

  // Command kinds decided by the front end
  localparam int KIND_W = 4;
  localparam logic [KIND_W-1:0] K_PRINT  = 4'd0;
  localparam logic [KIND_W-1:0] K_BS     = 4'd1;
  localparam logic [KIND_W-1:0] K_TAB    = 4'd2;
  localparam logic [KIND_W-1:0] K_CR     = 4'd3;
  localparam logic [KIND_W-1:0] K_LF     = 4'd4;
  localparam logic [KIND_W-1:0] K_IGNORE = 4'd5;
  localparam logic [KIND_W-1:0] K_CLEAR  = 4'd6;
  localparam logic [KIND_W-1:0] K_SETCUR = 4'd7;
  localparam logic [KIND_W-1:0] K_READ   = 4'd8;

  // Classified command, position already clamped to the screen
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cmd_t;

  // Cell word: background in 15:12, foreground in 11:8, code in 7:0
  function automatic logic [WORD_W-1:0] attr_word(input logic [COLOR_W-1:0] fg,
                                                  input logic [COLOR_W-1:0] bg,
                                                  input logic [CODE_W-1:0] code);
    return {bg, fg, code};
  endfunction

endpackage

// ===== rtl/tcw_ifs.sv =====
// Request channel
interface tcw_cmd_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CODE_W-1:0] char_code;
  logic [COL_W-1:0]  cell_col;
  logic [ROW_W-1:0]  cell_row;

  modport source (output valid, output op, output char_code, output cell_col,
                  output cell_row, input ready);
  modport sink (input valid, input op, input char_code, input cell_col,
                input cell_row, output ready);
endinterface

// Result channel
interface tcw_res_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  col_now;
  logic [ROW_W-1:0]  row_now;
  logic [OFF_W-1:0]  cursor_offset;
  logic [WORD_W-1:0] cell_word;
  logic              scrolled;

  modport source (output valid, output col_now, output row_now, output cursor_offset,
                  output cell_word, output scrolled, input ready);
  modport sink (input valid, input col_now, input row_now, input cursor_offset,
                input cell_word, input scrolled, output ready);
endinterface

// Configuration write channel
interface tcw_cfg_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [COLOR_W-1:0]   data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/text_console_writer_unit.sv =====
// Request path: queue, sequencer, result register, for cursor moves, put and set cursor;
// read cell adds a wait state for the registered read of the cell store.
// A put that scrolls first blanks one row of the cell store (COLUMNS cells);
// clear screen blanks all COLUMNS*ROWS cells. Both sweeps use the one cell store write port.
// One request at a time in the back end, none during a sweep; 2-entry queue in front.
// Reset: synchronous; then a sweep blanks all COLUMNS*ROWS store cells (2000 at 80x25).
module text_console_writer_unit import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic      clk,
  input  logic      rst,
  tcw_cmd_if.sink   cmd,
  tcw_res_if.source res,
  tcw_cfg_if.sink   cfg
);

  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic               hold;
  logic               q_valid;
  logic               q_ready;
  cmd_t               q_cmd;

  // Colour registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= '0;
      bg_color <= '0;
    end else if (cfg.valid) begin
      case (cfg.addr)
        CFG_FG:  fg_color <= cfg.data;
        CFG_BG:  bg_color <= cfg.data;
        default: ;
      endcase
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .hold    (hold),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .fg        (fg_color),
    .bg        (bg_color),
    .init_busy (hold),
    .res       (res)
  );

endmodule

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tcw_front.sv =====
module tcw_front import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic      clk,
  input  logic      rst,
  tcw_cmd_if.sink   cmd,
  input  logic      hold,
  output logic      q_valid,
  input  logic      q_ready,
  output cmd_t      q_cmd
);

  localparam int QD = 2;

  cmd_t             cls;
  cmd_t             q_mem [QD];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       cnt;
  logic             push;
  logic             pop;

  // Classify the request and clamp its position to the screen
  always_comb begin
    cls.code = cmd.char_code;
    cls.col  = (cmd.cell_col >= COLUMNS) ? COL_W'(COLUMNS - 1) : cmd.cell_col;
    cls.row  = (cmd.cell_row >= ROWS) ? ROW_W'(ROWS - 1) : cmd.cell_row;
    case (cmd.op)
      OP_PUT: begin
        case (cmd.char_code)
          CH_BS:   cls.kind = K_BS;
          CH_TAB:  cls.kind = K_TAB;
          CH_CR:   cls.kind = K_CR;
          CH_LF:   cls.kind = K_LF;
          default: cls.kind = (cmd.char_code < CH_SPACE) ? K_IGNORE : K_PRINT;
        endcase
      end
      OP_CLEAR:  cls.kind = K_CLEAR;
      OP_SETCUR: cls.kind = K_SETCUR;
      OP_READ:   cls.kind = K_READ;
      default:   cls.kind = K_IGNORE;
    endcase
  end

  // Two-entry queue towards the back end
  assign cmd.ready = !hold && (cnt != 2'(QD));
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (cnt != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_cmd     = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== rtl/tcw_back.sv =====
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  cmd_t               q_cmd,
  input  logic [COLOR_W-1:0] fg,
  input  logic [COLOR_W-1:0] bg,
  output logic               init_busy,
  tcw_res_if.source          res
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SWEEP  = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_POST   = 3'd4;

  logic [2:0]        state;
  logic [CW-1:0]     cur_col;
  logic [RW-1:0]     cur_row;
  logic [RW-1:0]     top;
  logic [AW-1:0]     sw_addr;
  logic [AW-1:0]     sw_last;
  logic [WORD_W-1:0] sw_word;
  logic [WORD_W-1:0] word;
  logic              scr;
  logic              out_valid;

  logic              take;
  logic              load;
  logic              sweeping;
  logic [CW-1:0]     addr_col;
  logic [RW-1:0]     addr_row;
  logic [RW:0]       prow_sum;
  logic [RW-1:0]     prow;
  logic [AW-1:0]     cell_addr;
  logic [AW-1:0]     top_base;
  logic [CW:0]       col_adv;
  logic              row_inc;
  logic [CW-1:0]     col_next;
  logic [RW-1:0]     row_next;
  logic [RW-1:0]     top_next;
  logic              scroll;
  logic [WORD_W-1:0] blank;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [WORD_W-1:0] ram_rdata;
  logic [AW-1:0]     off_full;
  logic [CW+COL_W-1:0] col_pad;
  logic [RW+ROW_W-1:0] row_pad;
  logic [AW+OFF_W-1:0] off_pad;

  assign take      = (state == S_IDLE) && q_valid;
  assign q_ready   = take;
  assign load      = (state == S_POST) && (!out_valid || res.ready);
  assign sweeping  = (state == S_SWEEP) || (state == S_INIT);
  assign init_busy = (state == S_INIT);
  assign blank     = attr_word(fg, bg, CH_SPACE);

  // Logical to physical cell address through the ring of rows
  assign addr_col  = (q_cmd.kind == K_READ) ? CW'(q_cmd.col) : cur_col;
  assign addr_row  = (q_cmd.kind == K_READ) ? RW'(q_cmd.row) : cur_row;
  assign prow_sum  = {1'b0, addr_row} + {1'b0, top};
  assign prow      = (prow_sum >= ROWS) ? RW'(prow_sum - (RW+1)'(ROWS)) : prow_sum[RW-1:0];
  assign cell_addr = AW'(prow * COLUMNS) + AW'(addr_col);
  assign top_base  = AW'(top * COLUMNS);

  // Cursor movement, wrap and scroll decision
  always_comb begin
    row_inc = 1'b0;
    case (q_cmd.kind)
      K_PRINT: col_adv = {1'b0, cur_col} + (CW+1)'(1);
      K_BS:    col_adv = (cur_col == '0) ? '0 : {1'b0, cur_col} - (CW+1)'(1);
      K_TAB:   col_adv = ({1'b0, cur_col} + (CW+1)'(TAB_STOP)) & ~(CW+1)'(TAB_STOP - 1);
      K_CR:    col_adv = '0;
      K_LF: begin
        col_adv = '0;
        row_inc = 1'b1;
      end
      default: col_adv = {1'b0, cur_col};
    endcase
    col_next = col_adv[CW-1:0];
    if (col_adv >= COLUMNS) begin
      col_next = '0;
      row_inc  = 1'b1;
    end
    scroll   = 1'b0;
    row_next = cur_row;
    top_next = top;
    if (row_inc) begin
      if (cur_row == RW'(ROWS - 1)) begin
        scroll   = 1'b1;
        top_next = (top == RW'(ROWS - 1)) ? '0 : top + RW'(1);
      end else begin
        row_next = cur_row + RW'(1);
      end
    end
  end

  // Cell store port selection
  assign ram_we    = sweeping || (take && (q_cmd.kind == K_PRINT));
  assign ram_waddr = sweeping ? sw_addr : cell_addr;
  assign ram_wdata = sweeping ? sw_word : attr_word(fg, bg, q_cmd.code);
  assign ram_re    = take && (q_cmd.kind == K_READ);

  tcw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      cur_col <= '0;
      cur_row <= '0;
      top     <= '0;
      sw_addr <= '0;
      sw_last <= AW'(CELLS - 1);
      sw_word <= RESET_WORD;
      word    <= '0;
      scr     <= 1'b0;
    end else begin
      case (state)
        S_INIT, S_SWEEP: begin
          sw_addr <= sw_addr + AW'(1);
          if (sw_addr == sw_last) begin
            state <= (state == S_INIT) ? S_IDLE : S_POST;
          end
        end
        S_IDLE: begin
          if (take) begin
            word <= '0;
            case (q_cmd.kind)
              K_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
                top     <= '0;
                sw_addr <= '0;
                sw_last <= AW'(CELLS - 1);
                sw_word <= blank;
                scr     <= 1'b0;
                state   <= S_SWEEP;
              end
              K_SETCUR: begin
                cur_col <= CW'(q_cmd.col);
                cur_row <= RW'(q_cmd.row);
                scr     <= 1'b0;
                state   <= S_POST;
              end
              K_READ: begin
                scr   <= 1'b0;
                state <= S_RDWAIT;
              end
              default: begin
                cur_col <= col_next;
                cur_row <= row_next;
                top     <= top_next;
                scr     <= scroll;
                if (scroll) begin
                  // old top row becomes the new bottom row
                  sw_addr <= top_base;
                  sw_last <= top_base + AW'(COLUMNS - 1);
                  sw_word <= blank;
                  state   <= S_SWEEP;
                end else begin
                  state   <= S_POST;
                end
              end
            endcase
          end
        end
        S_RDWAIT: begin
          word  <= ram_rdata;
          state <= S_POST;
        end
        S_POST: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register
  assign off_full = AW'(cur_row * COLUMNS) + AW'(cur_col);
  assign col_pad  = {{COL_W{1'b0}}, cur_col};
  assign row_pad  = {{ROW_W{1'b0}}, cur_row};
  assign off_pad  = {{OFF_W{1'b0}}, off_full};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.col_now       <= col_pad[COL_W-1:0];
      res.row_now       <= row_pad[ROW_W-1:0];
      res.cursor_offset <= off_pad[OFF_W-1:0];
      res.cell_word     <= word;
      res.scrolled      <= scr;
    end
  end

  assign res.valid = out_valid;

  // Checks
  a_no_take_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP || state == S_INIT) |-> !q_ready)
    else $error("command taken during a sweep");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (load && scr) |-> (cur_row == RW'(ROWS - 1)))
    else $error("scroll reported off the last row");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (cur_col < COLUMNS) && (cur_row < ROWS) && (top < ROWS))
    else $error("cursor or ring base out of range");

endmodule
